### design/gto_pkg.sv
`timescale 1ns / 1ps
package gto_pkg;

   localparam int MAX_VERTICES_DEF = 32;
   localparam int QUEUE_DEPTH      = 4;

   localparam int FIELD_VERTEX_W = 6;
   localparam int FIELD_ROW_W    = 32;
   localparam int CSR_INDEX_W    = 2;
   localparam int CSR_DATA_W     = 6;

   localparam logic [CSR_INDEX_W-1:0] CSR_VERTEX_COUNT = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SEARCH_MODE  = 2'd1;

   localparam logic [FIELD_VERTEX_W-1:0] VERTEX_COUNT_RESET = 6'd32;

   localparam logic FUNC_LOAD  = 1'b0;
   localparam logic FUNC_START = 1'b1;

   localparam logic MODE_BREADTH = 1'b0;
   localparam logic MODE_STACK   = 1'b1;

   typedef enum logic [1:0] {
      KIND_LOAD  = 2'd0,
      KIND_START = 2'd1,
      KIND_BAD   = 2'd2
   } kind_type;

   typedef struct packed {
      kind_type                  kind;
      logic [FIELD_VERTEX_W-1:0] row_index;
      logic [FIELD_ROW_W-1:0]    row_bits;
      logic [FIELD_VERTEX_W-1:0] source;
   } entry_type;

   typedef struct packed {
      logic [FIELD_VERTEX_W-1:0] vertex_count;
      logic                      search_mode;
   } cfg_type;

endpackage

### design/gto_front.sv
`timescale 1ns / 1ps
module gto_front #(
   parameter int MAX_VERTICES = gto_pkg::MAX_VERTICES_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic                                req_func,
   input  logic [gto_pkg::FIELD_VERTEX_W-1:0]  req_row_index,
   input  logic [gto_pkg::FIELD_ROW_W-1:0]     req_row_bits,
   input  logic [gto_pkg::FIELD_VERTEX_W-1:0]  req_source,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [gto_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [gto_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  logic                                q_full,
   output logic                                q_push,
   output gto_pkg::entry_type                  q_entry,
   output gto_pkg::cfg_type                    cfg
);

   localparam int VW = $clog2(MAX_VERTICES + 1);

   logic [gto_pkg::FIELD_VERTEX_W-1:0] vertex_count_ff, vertex_count_in;
   logic                               search_mode_ff, search_mode_in;
   logic [VW-1:0]                      n_eff;
   logic                               accept;
   logic                               row_ok;
   logic                               src_ok;

   always_comb begin
      vertex_count_in = vertex_count_ff;
      search_mode_in  = search_mode_ff;
      if (csr_valid) begin
         unique case (csr_index)
            gto_pkg::CSR_VERTEX_COUNT: vertex_count_in = csr_wdata;
            gto_pkg::CSR_SEARCH_MODE:  search_mode_in  = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vertex_count_ff <= gto_pkg::VERTEX_COUNT_RESET;
         search_mode_ff  <= gto_pkg::MODE_BREADTH;
      end else begin
         vertex_count_ff <= vertex_count_in;
         search_mode_ff  <= search_mode_in;
      end
   end

   assign csr_ready = 1'b1;
   assign cfg.vertex_count = vertex_count_ff;
   assign cfg.search_mode  = search_mode_ff;

   // vertex count clamped to the store size
   assign n_eff = (7'(vertex_count_ff) > 7'(MAX_VERTICES)) ? VW'(MAX_VERTICES)
                                                            : VW'(vertex_count_ff);

   assign row_ok = (req_row_index != '0) && (7'(req_row_index) <= 7'(MAX_VERTICES));
   assign src_ok = (req_source != '0) && (7'(req_source) <= 7'(n_eff));

   assign busy   = q_full;
   assign accept = start && !busy;

   always_comb begin
      q_entry.row_index = req_row_index;
      q_entry.row_bits  = req_row_bits;
      q_entry.source    = req_source;
      if (req_func == gto_pkg::FUNC_LOAD) begin
         q_entry.kind = gto_pkg::KIND_LOAD;
         q_push       = accept && row_ok;
      end else begin
         q_entry.kind = src_ok ? gto_pkg::KIND_START : gto_pkg::KIND_BAD;
         q_push       = accept;
      end
   end

endmodule

### design/gto_queue.sv
`timescale 1ns / 1ps
module gto_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  gto_pkg::entry_type push_entry,
   output logic               full,
   input  logic               pop,
   output logic               head_valid,
   output gto_pkg::entry_type head_entry
);

   localparam int DEPTH = gto_pkg::QUEUE_DEPTH;
   localparam int PW    = $clog2(DEPTH);

   gto_pkg::entry_type slot_ff [DEPTH];
   logic [PW-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [PW:0]        count_ff, count_in;
   logic               do_push;
   logic               do_pop;

   assign full       = (count_ff == (PW + 1)'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = slot_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

### design/gto_back.sv
`timescale 1ns / 1ps
module gto_back #(
   parameter int MAX_VERTICES = gto_pkg::MAX_VERTICES_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  gto_pkg::cfg_type                   cfg,
   input  logic                               q_valid,
   input  gto_pkg::entry_type                 q_entry,
   output logic                               q_pop,
   output logic                               rsp_valid,
   output logic [gto_pkg::FIELD_VERTEX_W-1:0] rsp_vertex,
   output logic                               rsp_last,
   output logic                               rsp_bad_source
);

   localparam int VW = $clog2(MAX_VERTICES + 1);
   localparam int AW = $clog2(MAX_VERTICES);

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_SEED  = 6'b000010,
      ST_POP   = 6'b000100,
      ST_FETCH = 6'b001000,
      ST_ROW   = 6'b010000,
      ST_SCAN  = 6'b100000
   } state_type;

   function automatic logic [AW-1:0] low_index(input logic [MAX_VERTICES-1:0] x);
      logic [MAX_VERTICES-1:0] one_hot;
      logic [AW-1:0]           idx;
      one_hot = x & (~x + 1'b1);
      idx     = '0;
      for (int i = 0; i < MAX_VERTICES; i++) begin
         if (one_hot[i]) begin
            idx = idx | AW'(i);
         end
      end
      return idx;
   endfunction

   state_type               state_ff, state_in;
   logic [MAX_VERTICES-1:0] visited_ff, visited_in;
   logic [MAX_VERTICES-1:0] cand_ff, cand_in;
   logic [VW-1:0]           rp_ff, rp_in;
   logic [VW-1:0]           wp_ff, wp_in;
   logic [VW-1:0]           seed_ff, seed_in;
   logic [VW-1:0]           cnt_ff, cnt_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [gto_pkg::FIELD_VERTEX_W-1:0] rsp_vertex_ff, rsp_vertex_in;
   logic                    rsp_last_ff, rsp_last_in;
   logic                    rsp_bad_ff, rsp_bad_in;

   logic [MAX_VERTICES-1:0] adj_mem [MAX_VERTICES];
   logic [MAX_VERTICES-1:0] adj_valid_ff;
   logic [MAX_VERTICES-1:0] adj_rd_ff;
   logic                    adj_rd_valid_ff;
   logic                    adj_we, adj_re;
   logic [AW-1:0]           adj_wa, adj_ra;

   logic [VW-1:0]           pend_mem [MAX_VERTICES];
   logic [VW-1:0]           pend_rd_ff;
   logic                    pend_we, pend_re;
   logic [AW-1:0]           pend_wa, pend_ra;
   logic [VW-1:0]           pend_wd;

   logic [VW-1:0]           n_eff;
   logic [MAX_VERTICES-1:0] n_mask;
   logic [MAX_VERTICES-1:0] unvisited;
   logic [MAX_VERTICES-1:0] cand_low;

   assign n_eff = (7'(cfg.vertex_count) > 7'(MAX_VERTICES)) ? VW'(MAX_VERTICES)
                                                             : VW'(cfg.vertex_count);

   always_comb begin
      for (int i = 0; i < MAX_VERTICES; i++) begin
         n_mask[i] = (i < int'(n_eff));
      end
   end

   assign unvisited = ~visited_ff & n_mask;
   assign cand_low  = cand_ff & (~cand_ff + 1'b1);

   always_comb begin
      state_in      = state_ff;
      visited_in    = visited_ff;
      cand_in       = cand_ff;
      rp_in         = rp_ff;
      wp_in         = wp_ff;
      seed_in       = seed_ff;
      cnt_in        = cnt_ff;
      rsp_valid_in  = 1'b0;
      rsp_vertex_in = rsp_vertex_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_bad_in    = rsp_bad_ff;
      q_pop         = 1'b0;
      adj_we        = 1'b0;
      adj_wa        = AW'(q_entry.row_index - 1'b1);
      adj_re        = 1'b0;
      adj_ra        = AW'(pend_rd_ff - 1'b1);
      pend_we       = 1'b0;
      pend_wa       = AW'(wp_ff);
      pend_wd       = VW'(low_index(cand_ff)) + VW'(1);
      pend_re       = 1'b0;
      pend_ra       = AW'(rp_ff);

      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               unique case (q_entry.kind)
                  gto_pkg::KIND_LOAD: begin
                     adj_we = 1'b1;
                  end
                  gto_pkg::KIND_START: begin
                     visited_in = '0;
                     cnt_in     = '0;
                     seed_in    = VW'(q_entry.source);
                     state_in   = ST_SEED;
                  end
                  default: begin
                     rsp_valid_in  = 1'b1;
                     rsp_vertex_in = '0;
                     rsp_last_in   = 1'b1;
                     rsp_bad_in    = 1'b1;
                  end
               endcase
            end
         end
         ST_SEED: begin
            visited_in = visited_ff | (MAX_VERTICES'(1) << (seed_ff - 1'b1));
            pend_we    = 1'b1;
            pend_wa    = '0;
            pend_wd    = seed_ff;
            rp_in      = '0;
            wp_in      = VW'(1);
            state_in   = ST_POP;
         end
         ST_POP: begin
            pend_re = 1'b1;
            if (cfg.search_mode == gto_pkg::MODE_STACK) begin
               pend_ra = AW'(wp_ff - 1'b1);
               wp_in   = wp_ff - 1'b1;
            end else begin
               pend_ra = AW'(rp_ff);
               rp_in   = rp_ff + 1'b1;
            end
            state_in = ST_FETCH;
         end
         ST_FETCH: begin
            rsp_valid_in  = 1'b1;
            rsp_vertex_in = gto_pkg::FIELD_VERTEX_W'(pend_rd_ff);
            rsp_last_in   = (cnt_ff == n_eff - 1'b1);
            rsp_bad_in    = 1'b0;
            cnt_in        = cnt_ff + 1'b1;
            adj_re        = 1'b1;
            state_in      = ST_ROW;
         end
         ST_ROW: begin
            cand_in  = (adj_rd_valid_ff ? adj_rd_ff : '0) & ~visited_ff & n_mask;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (cand_ff != '0) begin
               visited_in = visited_ff | cand_low;
               cand_in    = cand_ff & ~cand_low;
               pend_we    = 1'b1;
               wp_in      = wp_ff + 1'b1;
            end else if (rp_ff < wp_ff) begin
               state_in = ST_POP;
            end else if (unvisited != '0) begin
               seed_in  = VW'(low_index(unvisited)) + VW'(1);
               state_in = ST_SEED;
            end else begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         adj_valid_ff <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (adj_we) begin
            adj_valid_ff[adj_wa] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      visited_ff    <= visited_in;
      cand_ff       <= cand_in;
      rp_ff         <= rp_in;
      wp_ff         <= wp_in;
      seed_ff       <= seed_in;
      cnt_ff        <= cnt_in;
      rsp_vertex_ff <= rsp_vertex_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_bad_ff    <= rsp_bad_in;
   end

   // adjacency rows, invalid rows read as zero
   always_ff @(posedge clock) begin
      if (adj_we) begin
         adj_mem[adj_wa] <= MAX_VERTICES'(q_entry.row_bits);
      end
      if (adj_re) begin
         adj_rd_ff       <= adj_mem[adj_ra];
         adj_rd_valid_ff <= adj_valid_ff[adj_ra];
      end
   end

   // pending vertices: queue or stack depending on mode
   always_ff @(posedge clock) begin
      if (pend_we) begin
         pend_mem[pend_wa] <= pend_wd;
      end
      if (pend_re) begin
         pend_rd_ff <= pend_mem[pend_ra];
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_vertex     = rsp_vertex_ff;
   assign rsp_last       = rsp_last_ff;
   assign rsp_bad_source = rsp_bad_ff;

endmodule

### design/graph_traversal_order_top.sv
`timescale 1ns / 1ps
// Breadth-first or stack-order traversal over an adjacency matrix held on chip.
// A load transfer (req_func 0) writes one row; a start transfer (req_func 1) emits
// all n vertices in visit order, n being vertex_count clamped to MAX_VERTICES. Each
// vertex takes a pending-store read, an adjacency-memory read and the scan set-up,
// and each newly found neighbour takes its own scan step. Each result is shown for
// exactly one cycle with rsp_valid high and cannot be stalled; rsp_last marks the
// final vertex. A bad source gives one result with vertex 0, rsp_last and
// rsp_bad_source high. Transfers are queued up to four deep ahead of the back end;
// busy is high while that queue is full. No clearing pass follows reset.
// Write csr_ registers only while the block is idle.
module graph_traversal_order_top #(
   parameter int MAX_VERTICES = gto_pkg::MAX_VERTICES_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic                                req_func,
   input  logic [gto_pkg::FIELD_VERTEX_W-1:0]  req_row_index,
   input  logic [gto_pkg::FIELD_ROW_W-1:0]     req_row_bits,
   input  logic [gto_pkg::FIELD_VERTEX_W-1:0]  req_source,
   output logic                                rsp_valid,
   output logic [gto_pkg::FIELD_VERTEX_W-1:0]  rsp_vertex,
   output logic                                rsp_last,
   output logic                                rsp_bad_source,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [gto_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [gto_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   logic               q_full;
   logic               q_push;
   logic               q_pop;
   logic               q_valid;
   gto_pkg::entry_type q_in_entry;
   gto_pkg::entry_type q_head_entry;
   gto_pkg::cfg_type   cfg;

   gto_front #(.MAX_VERTICES(MAX_VERTICES)) u_front (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_func      (req_func),
      .req_row_index (req_row_index),
      .req_row_bits  (req_row_bits),
      .req_source    (req_source),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_entry       (q_in_entry),
      .cfg           (cfg)
   );

   gto_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_in_entry),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_entry (q_head_entry)
   );

   gto_back #(.MAX_VERTICES(MAX_VERTICES)) u_back (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .q_valid        (q_valid),
      .q_entry        (q_head_entry),
      .q_pop          (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_vertex     (rsp_vertex),
      .rsp_last       (rsp_last),
      .rsp_bad_source (rsp_bad_source)
   );

endmodule

### design/gto_checker.sv
`timescale 1ns / 1ps
module gto_checker #(
   parameter int MAX_VERTICES = gto_pkg::MAX_VERTICES_DEF
) (
   input logic                                clock,
   input logic                                reset,
   input logic                                rsp_valid,
   input logic [gto_pkg::FIELD_VERTEX_W-1:0]  rsp_vertex,
   input logic                                rsp_last,
   input logic                                rsp_bad_source
);

   // flagged result is a lone, final, empty transfer
   a_bad_form: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_bad_source) |-> (rsp_last && (rsp_vertex == '0)))
      else $error("bad-source result malformed");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result strobe after reset");

   a_vertex_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_bad_source) |-> (7'(rsp_vertex) <= 7'(MAX_VERTICES)))
      else $error("vertex above store size");

endmodule

bind graph_traversal_order_top gto_checker #(.MAX_VERTICES(MAX_VERTICES)) u_checker (.*);

### bench/tb_graph_traversal_order_top.sv
`timescale 1ns / 1ps
module tb_graph_traversal_order_top;

   localparam int MAX_V         = gto_pkg::MAX_VERTICES_DEF;
   localparam int VW            = gto_pkg::FIELD_VERTEX_W;
   localparam int RW            = gto_pkg::FIELD_ROW_W;
   localparam int IW            = gto_pkg::CSR_INDEX_W;
   localparam int DW            = gto_pkg::CSR_DATA_W;
   localparam int SETTLE_CYCLES = 64;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int RANDOM_PHASES = 8;
   localparam int PHASE_ITEMS   = 12;

   typedef struct packed {
      logic [VW-1:0] vertex;
      logic          last;
      logic          bad_source;
   } visit_type;

   typedef enum bit {
      STEP_ITEM,
      STEP_CSR
   } step_kind_type;

   typedef struct {
      step_kind_type kind;
      logic          func;
      logic [VW-1:0] row_index;
      logic [RW-1:0] row_bits;
      logic [VW-1:0] source;
      logic [IW-1:0] csr_sel;
      logic [DW-1:0] csr_value;
      bit            typed;
      visit_type     typed_visit;
   } step_type;

   logic          clock          = 1'b0;
   logic          reset          = 1'b1;
   logic          start          = 1'b0;
   logic          req_func       = gto_pkg::FUNC_LOAD;
   logic [VW-1:0] req_row_index  = '0;
   logic [RW-1:0] req_row_bits   = '0;
   logic [VW-1:0] req_source     = '0;
   logic          csr_valid      = 1'b0;
   logic [IW-1:0] csr_index      = '0;
   logic [DW-1:0] csr_wdata      = '0;
   logic          busy;
   logic          rsp_valid;
   logic [VW-1:0] rsp_vertex;
   logic          rsp_last;
   logic          rsp_bad_source;
   logic          csr_ready;

   // shadow of the block: adjacency rows by vertex number, configuration
   logic [RW-1:0]    adj_rows [1:MAX_V];
   gto_pkg::cfg_type shadow_cfg;
   visit_type        expected_visits [$];
   step_type         plan [$];

   int        idle_pct;
   int        cycle_count;
   int        fail_count;
   int        load_count;
   int        start_count;
   int        visit_count;
   int        bad_count;
   int        csr_count;
   visit_type got_visit;
   visit_type want_visit;

   graph_traversal_order_top u_dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_func       (req_func),
      .req_row_index  (req_row_index),
      .req_row_bits   (req_row_bits),
      .req_source     (req_source),
      .rsp_valid      (rsp_valid),
      .rsp_vertex     (rsp_vertex),
      .rsp_last       (rsp_last),
      .rsp_bad_source (rsp_bad_source),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d visits outstanding", cycle_count,
                  expected_visits.size());
         $display("tb_graph_traversal_order_top NOT OK");
         $finish;
      end
   end

   function automatic int effective_count();
      return (shadow_cfg.vertex_count > MAX_V) ? MAX_V : int'(shadow_cfg.vertex_count);
   endfunction

   function automatic void note_failure(input string msg);
      fail_count++;
      if (fail_count <= 10)
         $display("MISMATCH @%0t: %s", $realtime, msg);
   endfunction

   // visit order of one traversal; a work store drained as a queue or as a stack
   function automatic void predict_traversal(input logic [VW-1:0] src);
      int               n;
      int               seed;
      int               head;
      int               tail;
      int               cur;
      int               work [MAX_V];
      logic [MAX_V-1:0] marked;
      visit_type        vis;
      n = effective_count();
      if (src == 0 || src > n) begin
         vis = '{vertex: '0, last: 1'b1, bad_source: 1'b1};
         expected_visits.push_back(vis);
         bad_count++;
         return;
      end
      marked = '0;
      seed = src;
      while (seed != 0) begin
         head = 0;
         tail = 0;
         marked[seed-1] = 1'b1;
         work[tail] = seed;
         tail++;
         while (head < tail) begin
            if (shadow_cfg.search_mode == gto_pkg::MODE_BREADTH) begin
               cur = work[head];
               head++;
            end else begin
               tail--;
               cur = work[tail];
            end
            vis = '{vertex: cur[VW-1:0], last: 1'b0, bad_source: 1'b0};
            expected_visits.push_back(vis);
            for (int j = 1; j <= n; j++) begin
               if (adj_rows[cur][j-1] && !marked[j-1]) begin
                  marked[j-1] = 1'b1;
                  work[tail] = j;
                  tail++;
               end
            end
         end
         seed = 0;
         for (int j = n; j >= 1; j--)
            if (!marked[j-1])
               seed = j;
      end
      vis = expected_visits.pop_back();
      vis.last = 1'b1;
      expected_visits.push_back(vis);
   endfunction

   function automatic step_type load_step(input logic [VW-1:0] row,
                                          input logic [RW-1:0] bits);
      step_type s;
      s = '{kind: STEP_ITEM, func: gto_pkg::FUNC_LOAD, row_index: row, row_bits: bits,
            source: '0, csr_sel: '0, csr_value: '0, typed: 1'b0, typed_visit: '0};
      return s;
   endfunction

   function automatic step_type start_step(input logic [VW-1:0] src);
      step_type s;
      s = load_step('0, '0);
      s.func = gto_pkg::FUNC_START;
      s.source = src;
      return s;
   endfunction

   function automatic step_type bad_step(input logic [VW-1:0] src);
      step_type s;
      s = start_step(src);
      s.typed = 1'b1;
      s.typed_visit = '{vertex: '0, last: 1'b1, bad_source: 1'b1};
      return s;
   endfunction

   function automatic step_type csr_step(input logic [IW-1:0] sel,
                                         input logic [DW-1:0] value);
      step_type s;
      s = load_step('0, '0);
      s.kind = STEP_CSR;
      s.csr_sel = sel;
      s.csr_value = value;
      return s;
   endfunction

   // entered just after a rising edge; returns at the edge of the transfer
   task automatic send_item(input step_type s);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start         <= 1'b1;
      req_func      <= s.func;
      req_row_index <= s.row_index;
      req_row_bits  <= s.row_bits;
      req_source    <= s.source;
      do
         @(negedge clock);
      while (busy);
      @(posedge clock);
      if (s.func == gto_pkg::FUNC_LOAD) begin
         load_count++;
         if (s.row_index >= 1 && s.row_index <= MAX_V)
            adj_rows[s.row_index] = s.row_bits;
      end else begin
         start_count++;
         if (s.typed) begin
            expected_visits.push_back(s.typed_visit);
            bad_count++;
         end else begin
            predict_traversal(s.source);
         end
      end
   endtask

   // waits for the block to go quiet, then one register transfer
   task automatic write_register(input logic [IW-1:0] sel,
                                 input logic [DW-1:0] value);
      start <= 1'b0;
      while (expected_visits.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= sel;
      csr_wdata <= value;
      do
         @(negedge clock);
      while (!csr_ready);
      @(posedge clock);
      csr_valid <= 1'b0;
      csr_count++;
      if (sel == gto_pkg::CSR_VERTEX_COUNT)
         shadow_cfg.vertex_count = value;
      else if (sel == gto_pkg::CSR_SEARCH_MODE)
         shadow_cfg.search_mode = value[0];
   endtask

   always @(negedge clock) begin
      if (!reset && rsp_valid) begin
         got_visit = '{vertex: rsp_vertex, last: rsp_last, bad_source: rsp_bad_source};
         if (expected_visits.size() == 0) begin
            note_failure($sformatf("unexpected result vertex %0d last %0b bad %0b",
                                   got_visit.vertex, got_visit.last, got_visit.bad_source));
         end else begin
            want_visit = expected_visits.pop_front();
            visit_count++;
            if (got_visit.vertex !== want_visit.vertex || got_visit.last !== want_visit.last
                || got_visit.bad_source !== want_visit.bad_source)
               note_failure($sformatf("vertex %0d/%0d last %0b/%0b bad %0b/%0b (exp/got)",
                                      want_visit.vertex, got_visit.vertex,
                                      want_visit.last, got_visit.last,
                                      want_visit.bad_source, got_visit.bad_source));
         end
      end
   end

   initial begin
      step_type      s;
      int            n;
      int            vc;
      logic [RW-1:0] bits;

      fail_count  = 0;
      load_count  = 0;
      start_count = 0;
      visit_count = 0;
      bad_count   = 0;
      csr_count   = 0;
      idle_pct    = 0;
      for (int v = 1; v <= MAX_V; v++)
         adj_rows[v] = '0;
      shadow_cfg.vertex_count = gto_pkg::VERTEX_COUNT_RESET;
      shadow_cfg.search_mode  = gto_pkg::MODE_BREADTH;

      // directed: empty graph after reset, field extremes, ignored rows, both modes,
      // vertex count at one, zero and beyond the maximum
      plan.push_back(start_step(6'd1));
      plan.push_back(bad_step(6'd0));
      plan.push_back(bad_step(6'd33));
      plan.push_back(bad_step(6'd63));
      plan.push_back(load_step(6'd0, 32'hFFFF_FFFF));
      plan.push_back(load_step(6'd63, 32'hFFFF_FFFF));
      plan.push_back(load_step(6'd33, 32'hFFFF_FFFF));
      plan.push_back(start_step(6'd32));
      plan.push_back(load_step(6'd1, 32'hFFFF_FFFF));
      plan.push_back(load_step(6'd32, 32'h8000_0001));
      plan.push_back(load_step(6'd2, 32'h0000_000C));
      plan.push_back(load_step(6'd3, 32'hAAAA_AAAA));
      plan.push_back(start_step(6'd1));
      plan.push_back(start_step(6'd2));
      plan.push_back(start_step(6'd32));
      plan.push_back(csr_step(gto_pkg::CSR_SEARCH_MODE, {5'd0, gto_pkg::MODE_STACK}));
      plan.push_back(start_step(6'd1));
      plan.push_back(start_step(6'd2));
      plan.push_back(start_step(6'd31));
      plan.push_back(csr_step(gto_pkg::CSR_VERTEX_COUNT, 6'd1));
      plan.push_back(start_step(6'd1));
      plan.push_back(bad_step(6'd2));
      plan.push_back(csr_step(gto_pkg::CSR_VERTEX_COUNT, 6'd0));
      plan.push_back(bad_step(6'd1));
      plan.push_back(bad_step(6'd0));
      plan.push_back(csr_step(gto_pkg::CSR_VERTEX_COUNT, 6'd63));
      plan.push_back(start_step(6'd32));
      plan.push_back(bad_step(6'd33));
      plan.push_back(csr_step(gto_pkg::CSR_VERTEX_COUNT, 6'd2));
      plan.push_back(csr_step(gto_pkg::CSR_SEARCH_MODE, {5'd0, gto_pkg::MODE_BREADTH}));
      plan.push_back(start_step(6'd2));
      plan.push_back(load_step(6'd1, 32'h0000_0000));

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[k]) begin
         if (plan[k].kind == STEP_CSR)
            write_register(plan[k].csr_sel, plan[k].csr_value);
         else
            send_item(plan[k]);
      end

      // random: per phase a setting, then loads of random rows mixed with starts
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0:       vc = MAX_V;
            1:       vc = 1;
            2:       vc = 63;
            3:       vc = $urandom_range(12, 2);
            4:       vc = 0;
            5:       vc = $urandom_range(31, 13);
            6:       vc = 33;
            default: vc = $urandom_range(8, 2);
         endcase
         write_register(gto_pkg::CSR_VERTEX_COUNT, vc[DW-1:0]);
         write_register(gto_pkg::CSR_SEARCH_MODE,
                        {5'd0, phase[0] ? gto_pkg::MODE_STACK : gto_pkg::MODE_BREADTH});
         case (phase % 3)
            0:       idle_pct = 0;
            1:       idle_pct = 88;
            default: idle_pct = 8;
         endcase
         n = effective_count();
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            case ($urandom_range(4))
               0:       bits = $urandom();
               1:       bits = (32'h1 << $urandom_range(31)) | (32'h1 << $urandom_range(31));
               2:       bits = '0;
               3:       bits = '1;
               default: bits = $urandom() & $urandom();
            endcase
            if ($urandom_range(99) < 55) begin
               if ($urandom_range(99) < 85)
                  s = load_step(6'($urandom_range((n > 0) ? n : MAX_V, 1)), bits);
               else
                  s = load_step(6'($urandom_range(63)), bits);
            end else begin
               if (n > 0 && $urandom_range(99) < 85)
                  s = start_step(6'($urandom_range(n, 1)));
               else
                  s = start_step(6'($urandom_range(63)));
            end
            send_item(s);
         end
      end

      start <= 1'b0;
      while (expected_visits.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("%0d loads and %0d starts sent, %0d register writes, %0d phases",
               load_count, start_count, csr_count, RANDOM_PHASES + 1);
      $display("%0d results checked, %0d of them bad-source, %0d failures",
               visit_count, bad_count, fail_count);
      if (fail_count == 0) begin
         $display("tb_graph_traversal_order_top OK");
      end else begin
         $display("tb_graph_traversal_order_top NOT OK");
      end
      $finish;
   end

endmodule
